>>> rtl/core/fgn_pkg.sv
// Shared types, constants and arithmetic helpers for the fractal gradient noise block.
package fgn_pkg;

   localparam int OCTAVES_DEF   = 8;
   localparam int FRAC_BITS_DEF = 16;

   localparam int SUM_W   = 48;
   localparam int TOTAL_W = 21;
   localparam int CNT_W   = 5;
   localparam int DOT_W   = 20;
   localparam int NX_W    = 21;
   localparam int FADE_W  = 18;
   localparam int QUO_W   = 16;

   localparam logic [31:0] HASH_MUL_X = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
   localparam logic [31:0] HASH_MIX   = 32'd1274126177;
   localparam logic [31:0] SEED_STEP  = 32'd1013;

   localparam logic signed [17:0] GRAD_ONE  = 18'sd65536;
   localparam logic signed [17:0] GRAD_DIAG = 18'sd46341;

   localparam logic [1:0] REG_OCTAVES    = 2'd0;
   localparam logic [1:0] REG_LACUNARITY = 2'd1;
   localparam logic [1:0] REG_GAIN       = 2'd2;
   localparam logic [1:0] REG_SEED       = 2'd3;

   typedef struct packed {
      logic [31:0]               xc;
      logic [31:0]               yc;
      logic [31:0]               freq;
      logic [16:0]               amp;
      logic signed [SUM_W-1:0]   sum;
      logic [TOTAL_W-1:0]        total;
      logic [CNT_W-1:0]          cnt;
      logic [31:0]               seed;
   } carry_type;

   typedef struct packed {
      logic [SUM_W-1:0]   rem;
      logic [TOTAL_W:0]   den;
      logic [QUO_W-1:0]   quo;
      logic               neg;
      logic               ovf;
      logic               zero;
   } div_stage_type;

   function automatic logic signed [17:0] grad_x(input logic [2:0] g);
      logic signed [17:0] r;
      case (g)
         3'd0: r = GRAD_ONE;
         3'd1: r = -GRAD_ONE;
         3'd4, 3'd6: r = GRAD_DIAG;
         3'd5, 3'd7: r = -GRAD_DIAG;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [17:0] grad_y(input logic [2:0] g);
      logic signed [17:0] r;
      case (g)
         3'd2: r = GRAD_ONE;
         3'd3: r = -GRAD_ONE;
         3'd4, 3'd5: r = GRAD_DIAG;
         3'd6, 3'd7: r = -GRAD_DIAG;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [DOT_W-1:0] corner_dot(input logic [2:0] g,
                                                         input logic signed [17:0] dx,
                                                         input logic signed [17:0] dy);
      logic signed [39:0] acc;
      acc = 40'(dx) * 40'(grad_x(g)) + 40'(dy) * 40'(grad_y(g)) + 40'sd32768;
      return $signed(acc[DOT_W+15:16]);
   endfunction

   function automatic logic signed [NX_W-1:0] lerp(input logic signed [NX_W-1:0] a,
                                                  input logic signed [NX_W-1:0] b,
                                                  input logic signed [FADE_W-1:0] s);
      logic signed [21:0] diff;
      logic signed [39:0] p;
      logic signed [21:0] r;
      diff = 22'(b) - 22'(a);
      p    = 40'(diff) * 40'(s);
      r    = 22'(a) + $signed(p[37:16]);
      return r[NX_W-1:0];
   endfunction

endpackage

>>> rtl/core/fgn_cell.sv
// Octave cell: weighted lattice noise added to the running sum; cnt 0 passes through.
module fgn_cell #(
   parameter int COORD_FRAC_BITS = fgn_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic [15:0]        lacunarity,
   input  logic [15:0]        gain,
   input  logic               in_valid,
   input  fgn_pkg::carry_type in_carry,
   output logic               out_valid,
   output fgn_pkg::carry_type out_carry
);
   import fgn_pkg::*;

   localparam int F = COORD_FRAC_BITS;

   logic [6:0]  vld_ff;
   carry_type   car_ff [0:6];
   logic        out_vld_ff;
   carry_type   out_car_ff;
   carry_type   out_car_in;

   logic signed [64:0] sp [0:1];
   logic [31:0] s_in [0:1];
   logic [31:0] s_ff [0:1];

   logic [31:0]        cel   [0:1];
   logic [F+15:0]      fext  [0:1];
   logic [15:0]        f_in  [0:1];
   logic signed [20:0] fa    [0:1];
   logic signed [37:0] ta_in [0:1];
   logic [31:0]        sq    [0:1];
   logic [31:0]        hp_in, hq_in, hs_in;
   logic [31:0]        hp_ff, hq_ff, hs_ff;
   logic [15:0]        f_ff  [0:1];
   logic signed [37:0] ta_ff [0:1];
   logic [15:0]        cq_ff [0:1];

   logic [31:0]        hb;
   logic [31:0]        h     [0:3];
   logic [31:0]        hg    [0:3];
   logic [31:0]        hm    [0:3];
   logic [2:0]         idx_in [0:3];
   logic [2:0]         idx_ff [0:3];
   logic signed [21:0] b_in  [0:1];
   logic signed [21:0] b_ff  [0:1];
   logic [31:0]        dp    [0:1];
   logic [15:0]        d_ff  [0:1];
   logic [15:0]        f3_ff [0:1];

   logic signed [17:0]       dlo [0:1];
   logic signed [17:0]       dhi [0:1];
   logic signed [DOT_W-1:0]  dot_in [0:3];
   logic signed [DOT_W-1:0]  dot_ff [0:3];
   logic signed [38:0]       fp  [0:1];
   logic signed [FADE_W-1:0] fd_in [0:1];
   logic signed [FADE_W-1:0] fd_ff [0:1];

   logic signed [NX_W-1:0]   nx_ff [0:1];
   logic signed [FADE_W-1:0] v_ff;
   logic signed [NX_W-1:0]   val_ff;
   logic signed [38:0]       prod_ff;

   logic [47:0] fr_p;
   logic [32:0] am_p;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sp[k]   = $signed(k == 0 ? in_carry.xc : in_carry.yc) * $signed({1'b0, in_carry.freq});
         s_in[k] = sp[k][39:8];
         cel[k]  = 32'($signed(s_ff[k]) >>> F);
         fext[k] = {s_ff[k][F-1:0], 16'd0};
         f_in[k] = fext[k][F+15:F];
         fa[k]   = $signed({5'd0, f_in[k]}) * 21'sd6 - 21'sd983040;
         ta_in[k] = 38'($signed({1'b0, f_in[k]})) * 38'(fa[k]);
         sq[k]   = f_in[k] * f_in[k];
         b_in[k] = $signed(ta_ff[k][37:16]) + 22'sd655360;
         dp[k]   = cq_ff[k] * f_ff[k];
         dlo[k]  = $signed({2'd0, f3_ff[k]});
         dhi[k]  = $signed({2'd0, f3_ff[k]}) - 18'sd65536;
         fp[k]   = 39'($signed({1'b0, d_ff[k]})) * 39'(b_ff[k]);
         fd_in[k] = $signed(fp[k][FADE_W+15:16]);
      end
      hp_in = cel[0] * HASH_MUL_X;
      hq_in = cel[1] * HASH_MUL_Y;
      hs_in = car_ff[0].seed * HASH_MUL_X;
      hb    = hp_ff + hq_ff + hs_ff;
      h[0]  = hb;
      h[1]  = hb + HASH_MUL_X;
      h[2]  = hb + HASH_MUL_Y;
      h[3]  = hb + HASH_MUL_X + HASH_MUL_Y;
      for (int c = 0; c < 4; c++) begin
         hg[c]     = h[c] ^ (h[c] >> 13);
         hm[c]     = hg[c] * HASH_MIX;
         idx_in[c] = hm[c][2:0] ^ hm[c][18:16];
      end
      dot_in[0] = corner_dot(idx_ff[0], dlo[0], dlo[1]);
      dot_in[1] = corner_dot(idx_ff[1], dhi[0], dlo[1]);
      dot_in[2] = corner_dot(idx_ff[2], dlo[0], dhi[1]);
      dot_in[3] = corner_dot(idx_ff[3], dhi[0], dhi[1]);
   end

   always_comb begin
      fr_p       = car_ff[6].freq * lacunarity;
      am_p       = car_ff[6].amp * gain;
      out_car_in = car_ff[6];
      if (car_ff[6].cnt != '0) begin
         out_car_in.sum   = car_ff[6].sum + SUM_W'(prod_ff);
         out_car_in.total = car_ff[6].total + TOTAL_W'(car_ff[6].amp);
         out_car_in.cnt   = car_ff[6].cnt - 1'b1;
         out_car_in.seed  = car_ff[6].seed + SEED_STEP;
         out_car_in.freq  = fr_p[39:8];
         out_car_in.amp   = am_p[32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[5:0], in_valid};
         out_vld_ff <= vld_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[0] <= in_carry;
         for (int k = 1; k < 7; k++) car_ff[k] <= car_ff[k-1];
         out_car_ff <= out_car_in;
         for (int k = 0; k < 2; k++) begin
            s_ff[k]  <= s_in[k];
            f_ff[k]  <= f_in[k];
            ta_ff[k] <= ta_in[k];
            cq_ff[k] <= sq[k][31:16];
            b_ff[k]  <= b_in[k];
            d_ff[k]  <= dp[k][31:16];
            f3_ff[k] <= f_ff[k];
            fd_ff[k] <= fd_in[k];
         end
         hp_ff <= hp_in;
         hq_ff <= hq_in;
         hs_ff <= hs_in;
         for (int c = 0; c < 4; c++) begin
            idx_ff[c] <= idx_in[c];
            dot_ff[c] <= dot_in[c];
         end
         nx_ff[0] <= lerp(NX_W'(dot_ff[0]), NX_W'(dot_ff[1]), fd_ff[0]);
         nx_ff[1] <= lerp(NX_W'(dot_ff[2]), NX_W'(dot_ff[3]), fd_ff[0]);
         v_ff     <= fd_ff[1];
         val_ff   <= lerp(nx_ff[0], nx_ff[1], v_ff);
         prod_ff  <= 39'(val_ff) * 39'($signed({1'b0, car_ff[5].amp}));
      end
   end

   assign out_valid = out_vld_ff;
   assign out_carry = out_car_ff;

endmodule

>>> rtl/core/fgn_div.sv
// Pipelined restoring divider: weighted sum over twice the total amplitude, saturated, or zero for a zero total.
module fgn_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [fgn_pkg::SUM_W-1:0]    sum,
   input  logic [fgn_pkg::TOTAL_W-1:0]         total,
   output logic                                out_valid,
   output logic signed [15:0]                  out_value
);
   import fgn_pkg::*;

   div_stage_type       st_ff [0:QUO_W];
   div_stage_type       st_in [0:QUO_W];
   logic [QUO_W:0]      vld_ff;
   logic [SUM_W-1:0]    mag;
   logic [QUO_W-1:0]    q;

   always_comb begin
      mag             = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      st_in[0].rem    = mag;
      st_in[0].den    = {total, 1'b0};
      st_in[0].quo    = '0;
      st_in[0].neg    = sum[SUM_W-1];
      st_in[0].zero   = (total == '0);
      st_in[0].ovf    = mag >= {(SUM_W'({total, 1'b0})) << QUO_W};
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [SUM_W:0] trial;
      always_comb begin
         trial    = {1'b0, st_ff[j].rem} - {1'b0, SUM_W'(st_ff[j].den) << (QUO_W - 1 - j)};
         st_in[j+1] = st_ff[j];
         if (!trial[SUM_W]) begin
            st_in[j+1].rem              = trial[SUM_W-1:0];
            st_in[j+1].quo[QUO_W-1-j]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QUO_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= QUO_W; k++) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      q = st_ff[QUO_W].quo;
      if (st_ff[QUO_W].zero) begin
         out_value = 16'sd0;
      end else if (st_ff[QUO_W].neg) begin
         if (st_ff[QUO_W].ovf || q > 16'd32768) out_value = -16'sd32768;
         else out_value = $signed(-q);
      end else begin
         if (st_ff[QUO_W].ovf || q > 16'd32767) out_value = 16'sd32767;
         else out_value = $signed(q);
      end
   end

   assign out_valid = vld_ff[QUO_W];

endmodule

>>> rtl/core/fractal_gradient_noise_2d.sv
// Top level of the fractal gradient noise block: config registers, octave chain, divider, output skid.
//
// Usage:
//   req_* carries one sample point per transfer: tdata holds x_coord in bits 31:0 and
//   y_coord in bits 63:32, both signed fixed point with COORD_FRAC_BITS fraction bits.
//   rsp_* returns one signed Q1.15 noise value per accepted point, in order.
//   csr_* writes the registers: 0 octave count, 1 lacunarity (Q8.8),
//   2 gain (Q0.16), 3 noise seed. Write only while no point is in flight.
// Throughput: one point per cycle, sustained while rsp_tready stays high.
// Pipeline: an input register, then MAX_OCTAVES octave cells, each an eight-stage pipeline,
//   then the final divide, which retires one quotient bit per stage, then the output register.
//   Unused octave cells still pass the point along.
// Reset: registers return to 4 octaves, lacunarity 2.0, gain 0.5, seed 0; the pipeline
//   empties and both channels go idle.
// Stall: while rsp_tready is low the held result stays on rsp_tdata; one more result
//   lands in a skid register, after which the whole pipeline holds and req_tready drops.
module fractal_gradient_noise_2d #(
   parameter int MAX_OCTAVES     = fgn_pkg::OCTAVES_DEF,
   parameter int COORD_FRAC_BITS = fgn_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_coord, y_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // noise_value
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import fgn_pkg::*;

   logic [3:0]  oct_ff;
   logic [15:0] lac_ff;
   logic [15:0] gain_ff;
   logic [31:0] seed_ff;

   logic        adv;
   logic        in_vld_ff;
   carry_type   in_car_ff;
   carry_type   in_car_in;
   logic [CNT_W-1:0] n_oct;

   logic        cv   [0:MAX_OCTAVES];
   carry_type   cc   [0:MAX_OCTAVES];

   logic               dv_valid;
   logic signed [15:0] dv_value;

   logic        out_vld_ff, skid_vld_ff;
   logic [15:0] out_ff, skid_ff;
   logic        take;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff  <= 4'd4;
         lac_ff  <= 16'd512;
         gain_ff <= 16'd32768;
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_OCTAVES:    oct_ff  <= csr_data[3:0];
            REG_LACUNARITY: lac_ff  <= csr_data[15:0];
            REG_GAIN:       gain_ff <= csr_data[15:0];
            REG_SEED:       seed_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv        = ~skid_vld_ff;
   assign req_tready = adv;
   assign take       = out_vld_ff & rsp_tready;

   always_comb begin
      n_oct = (CNT_W'(oct_ff) > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES) : CNT_W'(oct_ff);
      in_car_in.xc    = req_tdata[31:0];
      in_car_in.yc    = req_tdata[63:32];
      in_car_in.freq  = 32'd256;
      in_car_in.amp   = 17'd65536;
      in_car_in.sum   = '0;
      in_car_in.total = '0;
      in_car_in.cnt   = n_oct;
      in_car_in.seed  = seed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) in_car_ff <= in_car_in;
   end

   assign cv[0] = in_vld_ff;
   assign cc[0] = in_car_ff;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      fgn_cell #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .lacunarity (lac_ff),
         .gain       (gain_ff),
         .in_valid   (cv[i]),
         .in_carry   (cc[i]),
         .out_valid  (cv[i+1]),
         .out_carry  (cc[i+1])
      );
   end

   fgn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cv[MAX_OCTAVES]),
      .sum       (cc[MAX_OCTAVES].sum),
      .total     (cc[MAX_OCTAVES].total),
      .out_valid (dv_valid),
      .out_value (dv_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) skid_vld_ff <= 1'b0;
      end else if (~out_vld_ff | take) begin
         out_vld_ff <= dv_valid;
      end else if (dv_valid) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) out_ff <= skid_ff;
      end else if (~out_vld_ff | take) begin
         out_ff <= dv_value;
      end else begin
         skid_ff <= dv_value;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

endmodule
